>>> hdl/cts_pkg.sv
// cts_pkg: shared types and character constants of the code token spacer.
// No dependencies; imported by cts_expand and code_token_spacer.
package cts_pkg;

  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChHash  = 8'd35;
  localparam logic [7:0] ChUnder = 8'd95;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChGt    = 8'd62;
  localparam logic [7:0] ChEq    = 8'd61;
  localparam logic [7:0] ChPct   = 8'd37;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChStar  = 8'd42;
  localparam logic [7:0] ChSlash = 8'd47;
  localparam logic [7:0] ChLt    = 8'd60;

  // Most words one input word can expand to
  localparam int unsigned MaxWords = 4;

  typedef enum logic [1:0] {
    LM_LEAD = 2'd0,  // leading spaces of a line
    LM_KEEP = 2'd1,  // inside a kept line
    LM_DROP = 2'd2   // inside a dropped line
  } line_mode_e;

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_present;
    line_mode_e line_mode;
    logic       lead_space;
    logic       last_space;
  } cts_state_t;

  typedef struct packed {
    logic [MaxWords-1:0][7:0] bytes;
    logic [2:0]               cnt;     // 0..4 words
    logic                     last;
    logic                     marker;  // empty end marker, no byte
  } cts_group_t;

endpackage

>>> hdl/cts_if.sv
// cts_if: valid/ready channel interfaces for the code token spacer.
// No dependencies.
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, in_char, end_of_text, input ready);
  modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       is_last;

  modport source (output valid, out_char, char_valid, is_last, input ready);
  modport sink   (input valid, out_char, char_valid, is_last, output ready);
endinterface

>>> hdl/cts_expand.sv
// cts_expand: per-word next-state and output-group logic of the token spacer.
// Depends on cts_pkg.
module cts_expand (
  input  cts_pkg::cts_state_t state_i,
  input  logic [7:0]          in_char_i,
  input  logic                eot_i,
  output cts_pkg::cts_state_t state_o,
  output cts_pkg::cts_group_t group_o
);
  import cts_pkg::*;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b >= 8'd9 && b <= 8'd13 && b != ChLf);
  endfunction

  function automatic logic is_math(input logic [7:0] b);
    return (b == ChEq) || (b == ChPlus) || (b == ChMinus) || (b == ChStar) ||
           (b == ChSlash) || (b == ChPct) || (b == ChGt) || (b == ChLt);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

  logic [MaxWords-1:0][7:0] raw;
  logic [2:0]               raw_cnt;
  logic [MaxWords-1:0][7:0] single_bytes;
  logic [2:0]               single_cnt;
  logic [7:0]               h;
  logic                     pair_hit;
  cts_state_t               state_raw;

  // Held byte on its own: punctuation other than underscore gets a space on each side
  always_comb begin
    h = state_i.held_byte;
    single_bytes = '0;
    if (is_punct(h) && h != ChUnder) begin
      single_bytes[0] = ChSpace;
      single_bytes[1] = h;
      single_bytes[2] = ChSpace;
      single_cnt      = 3'd3;
    end else begin
      single_bytes[0] = h;
      single_cnt      = 3'd1;
    end
    pair_hit = (h == ChMinus && in_char_i == ChGt) || (is_math(h) && is_math(in_char_i));
  end

  // Raw words before the whitespace filter
  always_comb begin
    state_raw = state_i;
    raw       = '0;
    raw_cnt   = 3'd0;
    if (eot_i) begin
      if (state_i.line_mode == LM_KEEP && state_i.held_present) begin
        raw     = single_bytes;
        raw_cnt = single_cnt;
      end
      state_raw = '0;
    end else if (in_char_i == ChLf) begin
      if (state_i.line_mode == LM_KEEP) begin
        if (state_i.held_present) begin
          raw     = single_bytes;
          raw_cnt = single_cnt;
        end
        state_raw.held_present = 1'b0;
        state_raw.held_byte    = 8'd0;
      end
      state_raw.line_mode  = LM_LEAD;
      state_raw.lead_space = 1'b0;
    end else begin
      unique case (state_i.line_mode)
        LM_LEAD: begin
          if (in_char_i == ChSpace) begin
            state_raw.lead_space = 1'b1;
          end else if (in_char_i == ChHash) begin
            state_raw.line_mode  = LM_DROP;
            state_raw.lead_space = 1'b0;
          end else begin
            // nothing is held at the start of a line
            state_raw.line_mode = LM_KEEP;
            if (state_i.lead_space) begin
              raw[0]  = ChSpace;
              raw_cnt = 3'd1;
            end
            state_raw.lead_space   = 1'b0;
            state_raw.held_byte    = in_char_i;
            state_raw.held_present = 1'b1;
          end
        end
        LM_KEEP: begin
          if (state_i.held_present && pair_hit) begin
            raw[0]  = ChSpace;
            raw[1]  = h;
            raw[2]  = in_char_i;
            raw[3]  = ChSpace;
            raw_cnt = 3'd4;
            state_raw.held_byte    = 8'd0;
            state_raw.held_present = 1'b0;
          end else begin
            if (state_i.held_present) begin
              raw     = single_bytes;
              raw_cnt = single_cnt;
            end
            state_raw.held_byte    = in_char_i;
            state_raw.held_present = 1'b1;
          end
        end
        default: begin
          // dropped line: swallow everything up to the line end
        end
      endcase
    end
  end

  // Whitespace filter and compaction: a run keeps only its first word
  logic [MaxWords-1:0][7:0] kept;
  logic [2:0]               kept_cnt;
  logic                     ls;
  logic                     ws;

  always_comb begin
    kept     = '0;
    kept_cnt = 3'd0;
    ls       = state_i.last_space;
    ws       = 1'b0;
    for (int i = 0; i < MaxWords; i++) begin
      if (3'(i) < raw_cnt) begin
        ws = is_ws(raw[i]);
        if (!(ws && ls)) begin
          kept[kept_cnt[1:0]] = raw[i];
          kept_cnt            = kept_cnt + 3'd1;
        end
        ls = ws;
      end
    end
  end

  always_comb begin
    group_o.bytes  = kept;
    group_o.cnt    = kept_cnt;
    group_o.last   = eot_i;
    group_o.marker = 1'b0;
    if (eot_i && kept_cnt == 3'd0) begin
      group_o.bytes  = '0;
      group_o.cnt    = 3'd1;
      group_o.marker = 1'b1;
    end
  end

  // End of text clears the filter flag; otherwise it follows the last word seen
  logic last_space_next;
  assign last_space_next = eot_i ? 1'b0 : ls;

  always_comb begin
    state_o            = state_raw;
    state_o.last_space = last_space_next;
  end

endmodule

>>> hdl/code_token_spacer.sv
// code_token_spacer: top level of the source text token normalizer.
// Depends on cts_pkg, cts_if (cts_in_if, cts_out_if) and cts_expand.
//
// Takes one source byte per input word and delivers normalized token text one
// byte per output word. An input word expands into a group of zero to four
// output words held in an output register; the group drains at one word per
// cycle while out_o.ready is high, through the single-byte output channel. A
// new input word is taken in the cycle the last word of the previous group
// leaves. An
// end_of_text word flushes the held byte and flags the last word with is_last,
// or sends one empty word (char_valid low) if nothing remains. Comment lines,
// blank lines and line ends are removed; punctuation is spaced; whitespace runs
// collapse to their first byte. All state returns to reset after end_of_text.
module code_token_spacer (
  input  logic      clk_i,
  input  logic      rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o
);
  import cts_pkg::*;

  cts_state_t state_q;
  cts_state_t state_d;
  cts_group_t group_d;

  logic [MaxWords-1:0][7:0] bytes_q;
  logic [2:0]               cnt_q;
  logic [1:0]               idx_q;
  logic                     last_q;
  logic                     marker_q;

  logic in_fire;
  logic out_fire;
  logic last_word;

  cts_expand u_expand (
    .state_i   (state_q),
    .in_char_i (in_i.in_char),
    .eot_i     (in_i.end_of_text),
    .state_o   (state_d),
    .group_o   (group_d)
  );

  assign last_word = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign out_fire  = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 3'd0) || (out_o.ready && last_word);
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.out_char   = bytes_q[idx_q];
  assign out_o.char_valid = !marker_q;
  assign out_o.is_last    = last_q && last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      cnt_q   <= 3'd0;
      idx_q   <= 2'd0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && group_d.cnt != 3'd0) begin
        cnt_q <= group_d.cnt;
        idx_q <= 2'd0;
      end else if (out_fire) begin
        if (last_word) begin
          cnt_q <= 3'd0;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && group_d.cnt != 3'd0) begin
      bytes_q  <= group_d.bytes;
      last_q   <= group_d.last;
      marker_q <= group_d.marker;
    end
  end

endmodule

>>> dv/code_token_spacer_tb.sv
// code_token_spacer_tb: self-checking bench for the source text token normalizer.
// Depends on cts_pkg, cts_in_if / cts_out_if and code_token_spacer; a local model
// predicts every output word and a monitor compares them in order.
module code_token_spacer_tb;
  import cts_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       chv;
    logic       last;
  } tok_word_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  cts_in_if  in_bus ();
  cts_out_if out_bus ();

  code_token_spacer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state
  logic [7:0] hold_byte;
  logic       hold_valid;
  line_mode_e line_st;
  logic       lead_sp;
  logic       out_sp;
  int unsigned step_words;

  tok_word_t   pending_words[$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  function automatic bit is_blank(logic [7:0] b);
    return b == ChSpace || (b >= 8'd9 && b <= 8'd13 && b != ChLf);
  endfunction

  function automatic bit is_sign(logic [7:0] b);
    return b == ChEq || b == ChPlus || b == ChMinus || b == ChStar ||
           b == ChSlash || b == ChPct || b == ChGt || b == ChLt;
  endfunction

  function automatic bit is_punct(logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

  function automatic void clear_state();
    hold_byte  = 8'd0;
    hold_valid = 1'b0;
    line_st    = LM_LEAD;
    lead_sp    = 1'b0;
    out_sp     = 1'b0;
  endfunction

  function automatic void queue_word(tok_word_t w);
    pending_words = {pending_words, w};
  endfunction

  // Every produced byte goes through the whitespace-run filter
  function automatic void emit(logic [7:0] b);
    if (is_blank(b)) begin
      if (out_sp) return;
      out_sp = 1'b1;
    end else begin
      out_sp = 1'b0;
    end
    queue_word('{ch: b, chv: 1'b1, last: 1'b0});
    step_words++;
  endfunction

  function automatic void emit_single(logic [7:0] b);
    if (b != ChUnder && is_punct(b)) begin
      emit(ChSpace);
      emit(b);
      emit(ChSpace);
    end else begin
      emit(b);
    end
  endfunction

  function automatic void flush_hold();
    if (hold_valid) emit_single(hold_byte);
    hold_valid = 1'b0;
    hold_byte  = 8'd0;
  endfunction

  function automatic void line_byte(logic [7:0] c);
    logic [7:0] h;
    if (hold_valid) begin
      h = hold_byte;
      if ((h == ChMinus && c == ChGt) || (is_sign(h) && is_sign(c))) begin
        emit(ChSpace);
        emit(h);
        emit(c);
        emit(ChSpace);
        hold_valid = 1'b0;
        hold_byte  = 8'd0;
        return;
      end
      emit_single(h);
    end
    hold_byte  = c;
    hold_valid = 1'b1;
  endfunction

  function automatic void spacer_predict(logic [7:0] c, logic eot);
    step_words = 0;
    if (eot) begin
      if (line_st == LM_KEEP) flush_hold();
      if (step_words == 0) begin
        queue_word('{ch: 8'd0, chv: 1'b0, last: 1'b1});
      end else begin
        pending_words[pending_words.size()-1].last = 1'b1;
      end
      clear_state();
      return;
    end
    if (c == ChLf) begin
      if (line_st == LM_KEEP) flush_hold();
      line_st = LM_LEAD;
      lead_sp = 1'b0;
      return;
    end
    if (line_st == LM_LEAD) begin
      if (c == ChSpace) begin
        lead_sp = 1'b1;
      end else if (c == ChHash) begin
        line_st = LM_DROP;
        lead_sp = 1'b0;
      end else begin
        line_st = LM_KEEP;
        if (lead_sp) emit(ChSpace);
        lead_sp = 1'b0;
        line_byte(c);
      end
    end else if (line_st == LM_KEEP) begin
      line_byte(c);
    end
  endfunction

  initial clear_state();

  // Predict on input handshakes and check output words in one process,
  // so an expectation is always queued before its word can be compared.
  always @(posedge clk_i) begin : monitor
    tok_word_t got;
    tok_word_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) spacer_predict(in_bus.in_char, in_bus.end_of_text);
      if (out_bus.valid && out_bus.ready) begin
        got = '{ch: out_bus.out_char, chv: out_bus.char_valid, last: out_bus.is_last};
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, got char %02h valid %0b last %0b",
                   $time, got.ch, got.chv, got.last);
          err_cnt++;
        end else begin
          want = pending_words.pop_front();
          if (got != want) begin
            $display({"%0t: mismatch, expected char %02h valid %0b last %0b,",
                      " got char %02h valid %0b last %0b"},
                     $time, want.ch, want.chv, want.last, got.ch, got.chv, got.last);
            err_cnt++;
          end
        end
      end
    end
  end

  // Output side ready: random stalls, full-rate stretches, and a long hold-off on request
  initial begin : receiver
    int unsigned hold_cnt;
    hold_cnt = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one word, hold it until taken, then maybe idle a few cycles
  task automatic send_word(input logic [7:0] c, input logic eot);
    in_bus.valid       <= 1'b1;
    in_bus.in_char     <= c;
    in_bus.end_of_text <= eot;
    do @(posedge clk_i); while (!in_bus.ready);
    n_sent++;
    @(negedge clk_i);
    if (!no_idle) begin
      while ($urandom_range(99) < 11) begin
        in_bus.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      return ($urandom_range(1)) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
    end
    if (r < 28) return 8'($urandom_range(48, 57));
    if (r < 50) begin
      case ($urandom_range(7))
        0: return ChEq;
        1: return ChPlus;
        2: return ChMinus;
        3: return ChStar;
        4: return ChSlash;
        5: return ChPct;
        6: return ChGt;
        default: return ChLt;
      endcase
    end
    if (r < 60) begin
      case ($urandom_range(3))
        0: return 8'($urandom_range(33, 47));
        1: return 8'($urandom_range(58, 64));
        2: return 8'($urandom_range(91, 96));
        default: return 8'($urandom_range(123, 126));
      endcase
    end
    if (r < 70) return ChSpace;
    if (r < 76) begin
      case ($urandom_range(3))
        0: return 8'd9;
        1: return 8'd11;
        2: return 8'd12;
        default: return 8'd13;
      endcase
    end
    if (r < 81) return ChUnder;
    if (r < 88) return ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(128, 255));
    return 8'($urandom_range(255));
  endfunction

  // One line: comment, blank, noise or token text, usually closed by a line end
  task automatic send_line();
    int unsigned kind;
    kind = $urandom_range(99);
    repeat ($urandom_range(3)) send_word(ChSpace, 1'b0);
    if (kind < 10) begin
      send_word(ChHash, 1'b0);
      repeat ($urandom_range(4)) send_word(pick_byte(), 1'b0);
    end else if (kind < 18) begin
      // blank or spaces only
    end else if (kind < 30) begin
      repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 10)) send_word(pick_byte(), 1'b0);
    end
    if ($urandom_range(19) != 0) send_word(ChLf, 1'b0);
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b1);       // end of text with nothing pending: empty marker
    send_text(" a->b( \n");       // leading space, arrow pair, spaced punctuation
    send_text("#x\n");            // comment line
    send_text("  \n");            // spaces only
    send_text("\n");              // empty line
    send_text("\t=%_");           // tab keeps the line, sign pair, underscore as is
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b1);       // flushes held byte, char ignored
    wait_idle();
  endtask

  // Receiver holds off while sign pairs keep the group full
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (2) send_text(" x=-y->z+=1;<=%%**\n");
    send_word(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_full_rate();
    int unsigned stop_at;
    no_idle = 1'b1;
    stop_at = n_sent + 40;
    while (n_sent < stop_at) send_line();
    send_word(8'h00, 1'b1);
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_text();
    int unsigned stop_at;
    stop_at = n_sent + 170;
    while (n_sent < stop_at) begin
      send_line();
      if ($urandom_range(7) == 0) send_word(8'($urandom_range(255)), 1'b1);
    end
    send_word(8'($urandom_range(255)), 1'b1);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.in_char = 8'd0;
    in_bus.end_of_text = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_backpressure();
    test_full_rate();
    test_random_text();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
